FILE: rtl/p2c_pkg.sv
// p2c_pkg: shared widths, constants, types and the arctangent table for the
// point-to-cylinder block. No dependencies; imported by every rtl module.
package p2c_pkg;

  // Field widths
  localparam int CoordW    = 24;               // point, center, local coords
  localparam int AxisCompW = 18;               // one Q1.16 axis component
  localparam int AxisW     = 3 * AxisCompW;    // packed axis register
  localparam int AngleW    = 20;               // Q3.16 angle
  localparam int CfgIdxW   = 3;

  // Projection datapath
  localparam int DiffW = CoordW + 1;           // point - center, exact
  localparam int ProdW = DiffW + AxisCompW;    // one component product
  localparam int AccW  = ProdW + 2;            // sum of three products
  localparam int RndW  = AccW - 16;            // after rounding to Q.8

  // Radius datapath (digit-by-digit root, one result bit from two input bits per step)
  localparam int SqW       = 2 * CoordW;       // x^2 + y^2
  localparam int SqrtW     = SqW + 1;
  localparam int SqrtSteps = CoordW;

  // Angle datapath (vectoring CORDIC)
  localparam int CordW   = 35;                 // x, y scaled by 256 plus growth
  localparam int ZW      = 28;                 // angle accumulator, Q.24
  localparam int AtanLen = 24;

  localparam int HalfPiQ24 = 26353589;
  localparam int PiQ16     = 205887;
  localparam int HalfPiQ16 = 102944;
  localparam int TwoPiQ16  = 411775;

  // Queue between front and back
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_AXIS_U    = 3'd3,
    REG_AXIS_V    = 3'd4,
    REG_AXIS_W    = 3'd5,
    REG_FULL_TURN = 3'd6
  } cfg_reg_e;

  // How the angle of a point is found
  typedef enum logic [2:0] {
    KIND_CORDIC   = 3'd0,  // general point, run the rotations
    KIND_ZERO     = 3'd1,  // on the positive x side or at the origin
    KIND_PI       = 3'd2,  // on the negative x side
    KIND_POS_HALF = 3'd3,  // on the positive y side
    KIND_NEG_HALF = 3'd4   // on the negative y side
  } angle_kind_e;

  typedef logic [AxisW-1:0] axis_t;

  // One point in local coordinates, as carried through the queue
  typedef struct packed {
    logic signed [CoordW-1:0] lx;
    logic signed [CoordW-1:0] ly;
    logic signed [CoordW-1:0] lz;
    angle_kind_e              kind;
  } local_pt_t;

  // atan(2^-i) in Q.24
  function automatic logic signed [ZW-1:0] atan_q24(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = ZW'(13176795);
      1:  v = ZW'(7778716);
      2:  v = ZW'(4110060);
      3:  v = ZW'(2086331);
      4:  v = ZW'(1047214);
      5:  v = ZW'(524117);
      6:  v = ZW'(262123);
      7:  v = ZW'(131069);
      8:  v = ZW'(65536);
      9:  v = ZW'(32768);
      10: v = ZW'(16384);
      11: v = ZW'(8192);
      12: v = ZW'(4096);
      13: v = ZW'(2048);
      14: v = ZW'(1024);
      15: v = ZW'(512);
      16: v = ZW'(256);
      17: v = ZW'(128);
      18: v = ZW'(64);
      19: v = ZW'(32);
      20: v = ZW'(16);
      21: v = ZW'(8);
      22: v = ZW'(4);
      23: v = ZW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/point_to_cylinder.sv
// point_to_cylinder: Cartesian point to cylindrical radius, angle and height.
// Sustains one point per cycle unless the result stream holds it back, set by the
// 24-step root pipeline and the CORDIC beside it.
// A 4-entry queue separates the projection front from the root/angle back.
// Reset is asynchronous active low: pipes and queue empty, registers to the
// identity frame at the origin, angle in the half-turn range.
module point_to_cylinder
  import p2c_pkg::*;
#(
  parameter int ANGLE_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [AxisW-1:0]   cfg_wdata_i,
  // point stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [71:0]        s_axis_tdata,  // point_x[23:0], point_y[47:24], point_z[71:48]
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [71:0]        m_axis_tdata   // radius[23:0], angle[43:24], height[67:44], 0
);

  logic signed [CoordW-1:0] center_x_q, center_y_q, center_z_q;
  axis_t                    axis_u_q, axis_v_q, axis_w_q;
  logic                     full_turn_q;

  logic      fr_valid, fr_ready, bk_valid, bk_ready;
  local_pt_t fr_pt, bk_pt;

  logic [CoordW-1:0]        radius;
  logic signed [AngleW-1:0] angle;
  logic signed [CoordW-1:0] height;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= '0;
      center_y_q  <= '0;
      center_z_q  <= '0;
      axis_u_q    <= AxisW'(65536);
      axis_v_q    <= AxisW'(65536) << AxisCompW;
      axis_w_q    <= AxisW'(65536) << (2 * AxisCompW);
      full_turn_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CENTER_X:  center_x_q  <= cfg_wdata_i[CoordW-1:0];
        REG_CENTER_Y:  center_y_q  <= cfg_wdata_i[CoordW-1:0];
        REG_CENTER_Z:  center_z_q  <= cfg_wdata_i[CoordW-1:0];
        REG_AXIS_U:    axis_u_q    <= cfg_wdata_i;
        REG_AXIS_V:    axis_v_q    <= cfg_wdata_i;
        REG_AXIS_W:    axis_w_q    <= cfg_wdata_i;
        REG_FULL_TURN: full_turn_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  p2c_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .point_x_i   (s_axis_tdata[23:0]),
    .point_y_i   (s_axis_tdata[47:24]),
    .point_z_i   (s_axis_tdata[71:48]),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .center_z_i  (center_z_q),
    .axis_u_i    (axis_u_q),
    .axis_v_i    (axis_v_q),
    .axis_w_i    (axis_w_q),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_pt_o    (fr_pt)
  );

  p2c_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_pt),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_pt)
  );

  p2c_back #(
    .ANGLE_STAGES (ANGLE_STAGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .in_pt_i     (bk_pt),
    .full_turn_i (full_turn_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .radius_o    (radius),
    .angle_o     (angle),
    .height_o    (height)
  );

  // result beat packing
  assign m_axis_tdata = {4'b0, height, angle, radius};

endmodule

FILE: rtl/p2c_front.sv
// p2c_front: accepts points, subtracts the center, projects onto the three
// axes, saturates and classifies the angle case. Depends on p2c_pkg.
module p2c_front
  import p2c_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // point input
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  // frame
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic signed [CoordW-1:0] center_z_i,
  input  axis_t                    axis_u_i,
  input  axis_t                    axis_v_i,
  input  axis_t                    axis_w_i,
  // local point output
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output local_pt_t                out_pt_o
);

  localparam logic signed [RndW-1:0] SatHi = RndW'(8388607);
  localparam logic signed [RndW-1:0] SatLo = RndW'(-8388608);

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [DiffW-1:0] diff_q [3];
  logic signed [ProdW-1:0] prod_q [3][3];
  logic signed [RndW-1:0]  rnd_q  [3];
  local_pt_t               pt_q;

  logic signed [DiffW-1:0]     diff_d [3];
  logic signed [ProdW-1:0]     prod_d [3][3];
  logic signed [RndW-1:0]      rnd_d  [3];
  logic signed [AxisCompW-1:0] comp   [3][3];
  logic signed [AccW-1:0]      acc    [3];
  logic signed [CoordW-1:0]    sat    [3];
  local_pt_t                   pt_d;

  // whole pipe moves unless the last beat is blocked by a full queue
  assign adv         = !v4_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = v4_q;
  assign out_pt_o    = pt_q;

  // stage 1: exact difference to the center
  always_comb begin
    diff_d[0] = DiffW'(point_x_i) - DiffW'(center_x_i);
    diff_d[1] = DiffW'(point_y_i) - DiffW'(center_y_i);
    diff_d[2] = DiffW'(point_z_i) - DiffW'(center_z_i);
  end

  // stage 2: nine component products
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      comp[0][c] = axis_u_i[c*AxisCompW +: AxisCompW];
      comp[1][c] = axis_v_i[c*AxisCompW +: AxisCompW];
      comp[2][c] = axis_w_i[c*AxisCompW +: AxisCompW];
    end
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[a][c] = diff_q[c] * comp[a][c];
      end
    end
  end

  // stage 3: dot product sums, rounded half up to Q.8
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc[a] = AccW'(prod_q[a][0]) + AccW'(prod_q[a][1]) + AccW'(prod_q[a][2])
               + AccW'(32768);
      rnd_d[a] = acc[a][AccW-1:16];
    end
  end

  // stage 4: saturate and pick the angle case
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (rnd_q[a] > SatHi) begin
        sat[a] = SatHi[CoordW-1:0];
      end else if (rnd_q[a] < SatLo) begin
        sat[a] = SatLo[CoordW-1:0];
      end else begin
        sat[a] = rnd_q[a][CoordW-1:0];
      end
    end
    pt_d.lx = sat[0];
    pt_d.ly = sat[1];
    pt_d.lz = sat[2];
    if (sat[1] == '0) begin
      pt_d.kind = sat[0][CoordW-1] ? KIND_PI : KIND_ZERO;
    end else if (sat[0] == '0) begin
      pt_d.kind = sat[1][CoordW-1] ? KIND_NEG_HALF : KIND_POS_HALF;
    end else begin
      pt_d.kind = KIND_CORDIC;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      diff_q <= diff_d;
      prod_q <= prod_d;
      rnd_q  <= rnd_d;
      pt_q   <= pt_d;
    end
  end

endmodule

FILE: rtl/p2c_fifo.sv
// p2c_fifo: short register queue of local points between front and back.
// Depends on p2c_pkg for the entry type and depth.
module p2c_fifo
  import p2c_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  local_pt_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output local_pt_t pop_data_o
);

  local_pt_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]    count_q;
  logic                  push, pop;

  assign push_ready_o = (count_q != (QueuePtrW+1)'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

FILE: rtl/p2c_back.sv
// p2c_back: radius by a pipelined digit-by-digit square root and angle by a
// pipelined vectoring CORDIC, run side by side, plus the output register.
// Depends on p2c_pkg.
module p2c_back
  import p2c_pkg::*;
#(
  parameter int ANGLE_STAGES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  local_pt_t                in_pt_i,
  input  logic                     full_turn_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CoordW-1:0]        radius_o,
  output logic signed [AngleW-1:0] angle_o,
  output logic signed [CoordW-1:0] height_o
);

  localparam int AW = ZW + 1 - 8;   // rounded angle before clamping
  localparam logic signed [AW-1:0] PiA     = AW'(PiQ16);
  localparam logic signed [AW-1:0] HalfPiA = AW'(HalfPiQ16);
  localparam logic signed [AW-1:0] TwoPiA  = AW'(TwoPiQ16);

  logic adv;
  logic vout_q;

  // stage B0: squares and quadrant pre-rotation
  logic                    v0_q;
  logic [SqW-1:0]          sqx_q, sqy_q;
  logic signed [CordW-1:0] cx0_q, cy0_q;
  logic signed [ZW-1:0]    z0_q;
  angle_kind_e             kind0_q;
  logic signed [CoordW-1:0] lz0_q;

  logic signed [SqW-1:0]   sqx_d, sqy_d;
  logic signed [CordW-1:0] sx, sy, cx0_d, cy0_d;
  logic signed [ZW-1:0]    z0_d;

  // step pipeline, index 0 is stage B1 (sum of squares)
  logic                     vld_q  [SqrtSteps+1];
  logic [SqrtW-1:0]         rem_q  [SqrtSteps+1];
  logic [SqrtW-1:0]         root_q [SqrtSteps+1];
  logic signed [CordW-1:0]  cx_q   [SqrtSteps+1];
  logic signed [CordW-1:0]  cy_q   [SqrtSteps+1];
  logic signed [ZW-1:0]     z_q    [SqrtSteps+1];
  angle_kind_e              kind_q [SqrtSteps+1];
  logic signed [CoordW-1:0] lz_q   [SqrtSteps+1];

  // output stage
  logic [CoordW-1:0]        radius_q, radius_d;
  logic signed [AngleW-1:0] angle_q, angle_d;
  logic signed [CoordW-1:0] height_q;
  logic [SqrtW-1:0]         root_fin;
  logic signed [ZW:0]       z_rnd;
  logic signed [AW-1:0]     ang;

  assign adv         = !vout_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vout_q;
  assign radius_o    = radius_q;
  assign angle_o     = angle_q;
  assign height_o    = height_q;

  // B0: squares; x < 0 is turned by a quarter turn toward the right half
  always_comb begin
    sqx_d = in_pt_i.lx * in_pt_i.lx;
    sqy_d = in_pt_i.ly * in_pt_i.ly;
    sx = {{(CordW-CoordW-8){in_pt_i.lx[CoordW-1]}}, in_pt_i.lx, 8'b0};
    sy = {{(CordW-CoordW-8){in_pt_i.ly[CoordW-1]}}, in_pt_i.ly, 8'b0};
    cx0_d = sx;
    cy0_d = sy;
    z0_d  = '0;
    if (in_pt_i.lx[CoordW-1]) begin
      if (in_pt_i.ly > 0) begin
        cx0_d = sy;
        cy0_d = -sx;
        z0_d  = ZW'(HalfPiQ24);
      end else begin
        cx0_d = -sy;
        cy0_d = sx;
        z0_d  = -ZW'(HalfPiQ24);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      v0_q     <= in_valid_i;
      vld_q[0] <= v0_q;
    end
  end

  // B0 and B1 payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q     <= sqx_d;
      sqy_q     <= sqy_d;
      cx0_q     <= cx0_d;
      cy0_q     <= cy0_d;
      z0_q      <= z0_d;
      kind0_q   <= in_pt_i.kind;
      lz0_q     <= in_pt_i.lz;
      rem_q[0]  <= SqrtW'(sqx_q) + SqrtW'(sqy_q);
      root_q[0] <= '0;
      cx_q[0]   <= cx0_q;
      cy_q[0]   <= cy0_q;
      z_q[0]    <= z0_q;
      kind_q[0] <= kind0_q;
      lz_q[0]   <= lz0_q;
    end
  end

  // one root step and, while stages remain, one rotation per stage
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam logic [SqrtW-1:0] Bit = SqrtW'(1) << (2 * (SqrtSteps - 1 - k));

    logic [SqrtW-1:0]        trial, rem_d, root_d;
    logic signed [CordW-1:0] cx_d, cy_d;
    logic signed [ZW-1:0]    z_d;

    always_comb begin
      trial = root_q[k] + Bit;
      if (rem_q[k] >= trial) begin
        rem_d  = rem_q[k] - trial;
        root_d = (root_q[k] >> 1) + Bit;
      end else begin
        rem_d  = rem_q[k];
        root_d = root_q[k] >> 1;
      end
    end

    if (k < ANGLE_STAGES && k < AtanLen) begin : g_rot
      always_comb begin
        if (cy_q[k] < 0) begin
          cx_d = cx_q[k] - (cy_q[k] >>> k);
          cy_d = cy_q[k] + (cx_q[k] >>> k);
          z_d  = z_q[k] - atan_q24(k);
        end else begin
          cx_d = cx_q[k] + (cy_q[k] >>> k);
          cy_d = cy_q[k] - (cx_q[k] >>> k);
          z_d  = z_q[k] + atan_q24(k);
        end
      end
    end else begin : g_hold
      always_comb begin
        cx_d = cx_q[k];
        cy_d = cy_q[k];
        z_d  = z_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[k+1]  <= rem_d;
        root_q[k+1] <= root_d;
        cx_q[k+1]   <= cx_d;
        cy_q[k+1]   <= cy_d;
        z_q[k+1]    <= z_d;
        kind_q[k+1] <= kind_q[k];
        lz_q[k+1]   <= lz_q[k];
      end
    end
  end

  // output stage: round the root, round and clamp the angle, apply cases, wrap for full turn
  always_comb begin
    root_fin = root_q[SqrtSteps];
    if (rem_q[SqrtSteps] > root_q[SqrtSteps]) begin
      root_fin = root_q[SqrtSteps] + 1'b1;
    end
    radius_d = root_fin[CoordW-1:0];

    z_rnd = (ZW+1)'(z_q[SqrtSteps]) + (ZW+1)'(128);
    ang   = z_rnd[ZW:8];
    if (ang > PiA) begin
      ang = PiA;
    end else if (ang < -PiA) begin
      ang = -PiA;
    end
    case (kind_q[SqrtSteps])
      KIND_CORDIC:   ang = ang;
      KIND_ZERO:     ang = '0;
      KIND_PI:       ang = PiA;
      KIND_POS_HALF: ang = HalfPiA;
      KIND_NEG_HALF: ang = -HalfPiA;
      default:       ang = '0;
    endcase
    if (full_turn_i && ang[AW-1]) begin
      ang = ang + TwoPiA;
    end
    angle_d = ang[AngleW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (adv) begin
      vout_q <= vld_q[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      radius_q <= radius_d;
      angle_q  <= angle_d;
      height_q <= lz_q[SqrtSteps];
    end
  end

endmodule
